>>> src/lpfg_pkg.sv
// ----------------------------------------------------------------------------
// lpfg_pkg
// Types, codes and constants shared by the line-of-sight guidance block.
// ----------------------------------------------------------------------------
package lpfg_pkg;

    localparam int OP_W     = 3;
    localparam int COORD_W  = 32;
    localparam int VEL_W    = 16;
    localparam int STATUS_W = 2;
    localparam int ANGLE_W  = 16;
    localparam int SEG_W    = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    // datapath width of the CORDIC and error registers
    localparam int DW = 36;
    localparam int STEP_W = 5;
    localparam int ATAN_ENTRIES = 24;

    localparam logic [OP_W-1:0] OP_SAMPLE = 3'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 3'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd2;
    localparam logic [OP_W-1:0] OP_START  = 3'd3;
    localparam logic [OP_W-1:0] OP_STOP   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_NONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SET   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ABORT = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOKAHEAD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OVS_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 3'd4;

    localparam logic [31:0] HALF_TURN = 32'h8000_0000;
    localparam logic signed [32:0] INV_GAIN_Q24 = 33'sd10188014;

    function automatic logic [31:0] atan_at(input logic [STEP_W-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2F9;
            5'd15: v = 32'h0000517C;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A2F;
            5'd19: v = 32'h00000517;
            5'd20: v = 32'h0000028B;
            5'd21: v = 32'h00000145;
            5'd22: v = 32'h000000A2;
            5'd23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

>>> src/lpfg_if.sv
// ----------------------------------------------------------------------------
// lpfg_in_if / lpfg_out_if
// Valid/ready channels for guidance commands and guidance results.
// ----------------------------------------------------------------------------
interface lpfg_in_if import lpfg_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           op;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [VEL_W-1:0]   vel_x;
    logic signed [VEL_W-1:0]   vel_y;

    modport source (output valid, op, coord_x, coord_y, vel_x, vel_y, input ready);
    modport sink   (input valid, op, coord_x, coord_y, vel_x, vel_y, output ready);
endinterface

interface lpfg_out_if import lpfg_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status;
    logic signed [ANGLE_W-1:0] heading_cmd;
    logic signed [VEL_W-1:0]   speed_cmd;
    logic                      overshooting;
    logic [SEG_W-1:0]          segment_number;

    modport source (output valid, status, heading_cmd, speed_cmd, overshooting,
                    segment_number, input ready);
    modport sink   (input valid, status, heading_cmd, speed_cmd, overshooting,
                    segment_number, output ready);
endinterface

>>> src/lpfg_ram.sv
// ----------------------------------------------------------------------------
// lpfg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lpfg_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> src/los_path_follow_guidance.sv
// ----------------------------------------------------------------------------
// los_path_follow_guidance
// Line-of-sight waypoint guidance: waypoint table, segment tracking, heading
// command from one shared vectoring CORDIC and one shared multiplier.
// ----------------------------------------------------------------------------
// channel  dir  transfer when        payload
// i_item   in   valid & ready        op, coord_x, coord_y, vel_x, vel_y
// o_res    out  valid & ready        status, heading_cmd, speed_cmd,
//                                    overshooting, segment_number
// cfg      in   i_cfg_we             i_cfg_idx, i_cfg_data
//
// A sample runs up to three CORDIC passes (path, line of sight, sideslip) of
// N = min(CORDIC_STEPS, 24) micro-rotations at one micro-rotation per cycle,
// with serial multiplies for compensation, gain and distance.
// i_item.ready is high only while the sequencer is idle; a finished result
// waits in the output register, so one new command may be taken meanwhile.
// Synchronous active-low reset; the waypoint RAM is not cleared.
// ----------------------------------------------------------------------------
module los_path_follow_guidance import lpfg_pkg::*; #(
    parameter int MAX_POINTS   = 64,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    lpfg_in_if.sink               i_item,
    lpfg_out_if.source            o_res
);
    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int NSTEPS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NSTEPS - 1);

    typedef enum logic [16:0] {
        S_IDLE = 17'h00001,
        S_STRT = 17'h00002,
        S_PREP = 17'h00004,
        S_ROT  = 17'h00008,
        S_CMPY = 17'h00010,
        S_CMPX = 17'h00020,
        S_CMPW = 17'h00040,
        S_OVS  = 17'h00080,
        S_GAIN = 17'h00100,
        S_HEAD = 17'h00200,
        S_SQ1  = 17'h00400,
        S_SQ2  = 17'h00800,
        S_SQ3  = 17'h01000,
        S_SW1  = 17'h02000,
        S_SW2  = 17'h04000,
        S_SW3  = 17'h08000,
        S_DONE = 17'h10000
    } t_state;

    typedef enum logic [2:0] {
        M_PATH = 3'b001,
        M_LOS  = 3'b010,
        M_BETA = 3'b100
    } t_mode;

    t_state r_state;
    t_mode  r_mode;

    // configuration
    logic [30:0]        r_radius, r_lookahead;
    logic [15:0]        r_ovs_limit, r_gain;
    logic signed [15:0] r_speed;

    // table and path state
    logic [CW-1:0]              r_count, r_lp;
    logic signed [COORD_W-1:0]  r_sx, r_sy, r_ex, r_ey;
    logic                       r_running, r_armed;
    logic [15:0]                r_ticks;

    // latched command
    logic signed [COORD_W-1:0]  r_x, r_y;
    logic signed [VEL_W-1:0]    r_vx, r_vy;

    // CORDIC unit
    logic signed [DW-1:0] r_cx, r_cy, r_a0, r_a1, r_a2, r_a3;
    logic [31:0]          r_cz;
    logic [STEP_W-1:0]    r_step;

    logic signed [DW-1:0] r_ye, r_xke;
    logic [31:0]          r_gamma, r_los, r_beta;
    logic signed [63:0]   r_prod, r_d2;

    // result
    logic [STATUS_W-1:0]  r_st;
    logic [ANGLE_W-1:0]   r_head;
    logic [VEL_W-1:0]     r_spd;
    logic                 r_ovs;
    logic                 r_ovalid;
    logic [STATUS_W-1:0]  r_o_st;
    logic [ANGLE_W-1:0]   r_o_head;
    logic [VEL_W-1:0]     r_o_spd;
    logic                 r_o_ovs;
    logic [SEG_W-1:0]     r_o_seg;

    // RAM
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [63:0]   ram_rdata;

    function automatic logic signed [DW-1:0] sx32(input logic signed [31:0] v);
        return DW'(v);
    endfunction

    function automatic logic signed [DW-1:0] comp(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = p + 64'sd8388608;
        return DW'(t >>> 24);
    endfunction

    // ---- CORDIC micro-rotation ----
    logic                 cw;
    logic [31:0]          atan_v;
    logic signed [DW-1:0] n_cx, n_cy, n_a0, n_a1, n_a2, n_a3;
    logic [31:0]          n_cz;

    always_comb begin
        cw     = !r_cy[DW-1];
        atan_v = atan_at(r_step);
        if (cw) begin
            n_cx = r_cx + (r_cy >>> r_step);
            n_cy = r_cy - (r_cx >>> r_step);
            n_cz = r_cz + atan_v;
            n_a0 = r_a0 + (r_a1 >>> r_step);
            n_a1 = r_a1 - (r_a0 >>> r_step);
            n_a2 = r_a2 + (r_a3 >>> r_step);
            n_a3 = r_a3 - (r_a2 >>> r_step);
        end else begin
            n_cx = r_cx - (r_cy >>> r_step);
            n_cy = r_cy + (r_cx >>> r_step);
            n_cz = r_cz - atan_v;
            n_a0 = r_a0 - (r_a1 >>> r_step);
            n_a1 = r_a1 + (r_a0 >>> r_step);
            n_a2 = r_a2 - (r_a3 >>> r_step);
            n_a3 = r_a3 + (r_a2 >>> r_step);
        end
    end

    // ---- shared multiplier operand select ----
    logic signed [DW-1:0] m_a;
    logic signed [32:0]   m_b;
    logic signed [32:0]   beta33;

    always_comb begin
        beta33 = (r_beta == HALF_TURN) ? 33'sh0_8000_0000 : 33'($signed(r_beta));
        m_a = '0;
        m_b = '0;
        unique case (r_state)
            S_CMPY: begin
                m_a = r_a1;
                m_b = INV_GAIN_Q24;
            end
            S_CMPX: begin
                m_a = r_a2;
                m_b = INV_GAIN_Q24;
            end
            S_GAIN: begin
                m_a = DW'(beta33);
                m_b = $signed({17'b0, r_gain});
            end
            S_HEAD: begin
                m_a = r_xke;
                m_b = $signed(r_xke[32:0]);
            end
            S_SQ1: begin
                m_a = r_ye;
                m_b = $signed(r_ye[32:0]);
            end
            S_SQ2: begin
                m_a = $signed({5'b0, r_radius});
                m_b = $signed({2'b0, r_radius});
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    // ---- misc combinational ----
    logic signed [DW-1:0] dx, dy, d0, d1, d2, d3;
    logic                 xke_pos, in_range;
    logic [15:0]          n_ticks;
    logic                 n_armed;
    logic [31:0]          n_gamma, scaled, hsum;
    logic signed [63:0]   gprod;
    logic [CW-1:0]        lp_inc;
    logic [30:0]          lk;

    always_comb begin
        dx = sx32(r_ex) - sx32(r_sx);
        dy = sx32(r_ey) - sx32(r_sy);
        d0 = sx32(r_x) - sx32(r_sx);
        d1 = sx32(r_y) - sx32(r_sy);
        d2 = sx32(r_x) - sx32(r_ex);
        d3 = sx32(r_y) - sx32(r_ey);
        xke_pos  = !r_xke[DW-1] && (r_xke != '0);
        in_range = (r_xke > -36'sd2147483648) && (r_xke < 36'sd2147483648)
                && (r_ye > -36'sd2147483648) && (r_ye < 36'sd2147483648);
        n_armed = r_armed;
        n_ticks = r_ticks;
        n_gamma = r_gamma;
        if (xke_pos) begin
            n_gamma = r_gamma + HALF_TURN;
            n_armed = 1'b1;
            if (!r_armed) begin
                n_ticks = '0;
            end else if (r_ticks != 16'hFFFF) begin
                n_ticks = r_ticks + 16'd1;
            end
        end
        gprod  = r_prod + 64'sd2048;
        scaled = 32'(gprod >>> 12);
        hsum   = r_gamma + r_los - scaled + 32'h8000;
        lp_inc = r_lp + CW'(1);
        lk     = (r_lookahead == '0) ? 31'd1 : r_lookahead;
    end

    // ---- RAM ports ----
    always_comb begin
        ram_we    = (r_state == S_IDLE) && i_item.valid && (i_item.op == OP_APPEND)
                 && (r_count < CW'(MAX_POINTS));
        ram_waddr = AW'(r_count);
        ram_raddr = (r_state == S_SW1) ? ((lp_inc >= r_count) ? '0 : AW'(lp_inc))
                                       : AW'(r_lp);
    end

    lpfg_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata ({i_item.coord_x, i_item.coord_y}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ---- configuration ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius    <= 31'd65536;
            r_lookahead <= 31'd131072;
            r_ovs_limit <= 16'd300;
            r_speed     <= 16'sd128;
            r_gain      <= 16'd4096;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RADIUS:    r_radius    <= i_cfg_data;
                CFG_LOOKAHEAD: r_lookahead <= i_cfg_data;
                CFG_OVS_LIMIT: r_ovs_limit <= i_cfg_data[15:0];
                CFG_SPEED:     r_speed     <= $signed(i_cfg_data[15:0]);
                CFG_GAIN:      r_gain      <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // ---- multiplier register ----
    always_ff @(posedge i_clk) begin
        r_prod <= 64'(m_a * m_b);
    end

    // ---- sequencer ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_mode    <= M_PATH;
            r_count   <= '0;
            r_lp      <= '0;
            r_sx      <= '0;
            r_sy      <= '0;
            r_ex      <= '0;
            r_ey      <= '0;
            r_running <= 1'b0;
            r_armed   <= 1'b0;
            r_ticks   <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            // S_DONE reloads the output register itself
            if (r_ovalid && o_res.ready && (r_state != S_DONE)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_item.valid) begin
                        r_x    <= i_item.coord_x;
                        r_y    <= i_item.coord_y;
                        r_vx   <= i_item.vel_x;
                        r_vy   <= i_item.vel_y;
                        r_st   <= ST_NONE;
                        r_head <= '0;
                        r_spd  <= '0;
                        r_ovs  <= 1'b0;
                        case (i_item.op)
                            OP_APPEND: begin
                                if (r_count < CW'(MAX_POINTS)) begin
                                    r_count <= r_count + CW'(1);
                                end
                                r_state <= S_DONE;
                            end
                            OP_CLEAR: begin
                                r_count <= '0;
                                r_lp    <= '0;
                                r_state <= S_DONE;
                            end
                            OP_START: begin
                                r_running <= 1'b1;
                                if (r_count != '0) begin
                                    r_state <= S_STRT;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end
                            OP_STOP: begin
                                r_running <= 1'b0;
                                r_state   <= S_DONE;
                            end
                            OP_SAMPLE: begin
                                if (r_running && r_count >= CW'(2)) begin
                                    r_state <= S_PREP;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_STRT: begin
                    r_sx <= r_x;
                    r_sy <= r_y;
                    r_ex <= $signed(ram_rdata[63:32]);
                    r_ey <= $signed(ram_rdata[31:0]);
                    r_state <= S_DONE;
                end
                S_PREP: begin
                    r_gamma <= '0;
                    if (dx == '0 && dy == '0) begin
                        r_ye    <= d1;
                        r_xke   <= d2;
                        r_state <= S_OVS;
                    end else begin
                        r_mode <= M_PATH;
                        r_step <= '0;
                        if (dx[DW-1]) begin
                            r_cx <= -dx;
                            r_cy <= -dy;
                            r_cz <= HALF_TURN;
                            r_a0 <= -d0;
                            r_a1 <= -d1;
                            r_a2 <= -d2;
                            r_a3 <= -d3;
                        end else begin
                            r_cx <= dx;
                            r_cy <= dy;
                            r_cz <= '0;
                            r_a0 <= d0;
                            r_a1 <= d1;
                            r_a2 <= d2;
                            r_a3 <= d3;
                        end
                        r_state <= S_ROT;
                    end
                end
                S_ROT: begin
                    r_a0 <= n_a0;
                    r_a1 <= n_a1;
                    r_a2 <= n_a2;
                    r_a3 <= n_a3;
                    if (r_step == LAST_STEP) begin
                        unique case (r_mode)
                            M_PATH: begin
                                r_gamma <= n_cz;
                                r_state <= S_CMPY;
                            end
                            M_LOS: begin
                                r_los  <= n_cz;
                                r_beta <= '0;
                                if (r_vx != '0) begin
                                    // sideslip angle from the velocity vector
                                    r_mode <= M_BETA;
                                    r_step <= '0;
                                    if (r_vx[VEL_W-1]) begin
                                        r_cx <= -DW'(r_vx);
                                        r_cy <= -DW'(r_vy);
                                        r_cz <= HALF_TURN;
                                    end else begin
                                        r_cx <= DW'(r_vx);
                                        r_cy <= DW'(r_vy);
                                        r_cz <= '0;
                                    end
                                end else begin
                                    r_state <= S_GAIN;
                                end
                            end
                            M_BETA: begin
                                r_beta  <= n_cz;
                                r_state <= S_GAIN;
                            end
                            default: r_state <= S_GAIN;
                        endcase
                    end else begin
                        r_cx <= n_cx;
                        r_cy <= n_cy;
                        r_cz <= n_cz;
                        r_step <= r_step + STEP_W'(1);
                    end
                end
                S_CMPY: r_state <= S_CMPX;
                S_CMPX: begin
                    r_ye    <= comp(r_prod);
                    r_state <= S_CMPW;
                end
                S_CMPW: begin
                    r_xke   <= comp(r_prod);
                    r_state <= S_OVS;
                end
                S_OVS: begin
                    r_ovs   <= xke_pos;
                    r_gamma <= n_gamma;
                    r_armed <= n_armed;
                    r_ticks <= n_ticks;
                    if (xke_pos && n_ticks > r_ovs_limit) begin
                        r_st    <= ST_ABORT;
                        r_state <= S_DONE;
                    end else begin
                        r_mode <= M_LOS;
                        r_step <= '0;
                        r_cx   <= DW'(lk);
                        r_cy   <= xke_pos ? r_ye : -r_ye;
                        r_cz   <= '0;
                        r_state <= S_ROT;
                    end
                end
                S_GAIN: r_state <= S_HEAD;
                S_HEAD: begin
                    r_head  <= hsum[31:16];
                    r_spd   <= r_speed;
                    r_st    <= ST_SET;
                    r_state <= S_SQ1;
                end
                S_SQ1: begin
                    r_d2    <= r_prod;
                    r_state <= S_SQ2;
                end
                S_SQ2: begin
                    r_d2    <= r_d2 + r_prod;
                    r_state <= S_SQ3;
                end
                S_SQ3: begin
                    if (in_range && ($unsigned(r_d2) < $unsigned(r_prod))) begin
                        r_state <= S_SW1;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_SW1: r_state <= S_SW2;
                // read data: current entry during SW1/SW3, next entry during SW2
                S_SW2: begin
                    r_ex <= $signed(ram_rdata[63:32]);
                    r_ey <= $signed(ram_rdata[31:0]);
                    r_state <= S_SW3;
                end
                S_SW3: begin
                    r_sx <= $signed(ram_rdata[63:32]);
                    r_sy <= $signed(ram_rdata[31:0]);
                    r_armed <= 1'b0;
                    r_ticks <= '0;
                    if (lp_inc >= r_count) begin
                        r_lp <= '0;
                        r_st <= ST_DONE;
                    end else begin
                        r_lp <= lp_inc;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ovalid || o_res.ready) begin
                        r_ovalid <= 1'b1;
                        r_o_st   <= r_st;
                        r_o_head <= r_head;
                        r_o_spd  <= r_spd;
                        r_o_ovs  <= r_ovs;
                        r_o_seg  <= SEG_W'(r_lp);
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_item.ready         = (r_state == S_IDLE);
    assign o_res.valid          = r_ovalid;
    assign o_res.status         = r_o_st;
    assign o_res.heading_cmd    = $signed(r_o_head);
    assign o_res.speed_cmd      = $signed(r_o_spd);
    assign o_res.overshooting   = r_o_ovs;
    assign o_res.segment_number = r_o_seg;
endmodule
